// File: rtl/core/vcd_pkg.sv
package vcd_pkg;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW = $clog2(Q_DEPTH + 1);

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  typedef struct packed {
    logic [3:0] digit;
    logic       kind;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic       valid_res;
    logic [3:0] check_digit;
    logic       digit_error;
  } out_word_t;

  // one classified digit on its way to the back end
  typedef struct packed {
    logic [3:0] perm;
    logic       err;
    logic       last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [3:0] PERM_TAB [8][10] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9},
    '{4'd1, 4'd5, 4'd7, 4'd6, 4'd2, 4'd8, 4'd3, 4'd0, 4'd9, 4'd4},
    '{4'd5, 4'd8, 4'd0, 4'd3, 4'd7, 4'd9, 4'd6, 4'd1, 4'd4, 4'd2},
    '{4'd8, 4'd9, 4'd1, 4'd6, 4'd0, 4'd4, 4'd3, 4'd5, 4'd2, 4'd7},
    '{4'd9, 4'd4, 4'd5, 4'd3, 4'd1, 4'd2, 4'd6, 4'd8, 4'd7, 4'd0},
    '{4'd4, 4'd2, 4'd8, 4'd6, 4'd5, 4'd7, 4'd3, 4'd9, 4'd0, 4'd1},
    '{4'd2, 4'd7, 4'd9, 4'd3, 4'd8, 4'd0, 4'd6, 4'd4, 4'd1, 4'd5},
    '{4'd7, 4'd0, 4'd4, 4'd6, 4'd9, 4'd1, 4'd3, 4'd2, 4'd5, 4'd8}
  };

  // dihedral group d5 product
  localparam logic [3:0] MUL_TAB [10][10] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9},
    '{4'd1, 4'd2, 4'd3, 4'd4, 4'd0, 4'd6, 4'd7, 4'd8, 4'd9, 4'd5},
    '{4'd2, 4'd3, 4'd4, 4'd0, 4'd1, 4'd7, 4'd8, 4'd9, 4'd5, 4'd6},
    '{4'd3, 4'd4, 4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd5, 4'd6, 4'd7},
    '{4'd4, 4'd0, 4'd1, 4'd2, 4'd3, 4'd9, 4'd5, 4'd6, 4'd7, 4'd8},
    '{4'd5, 4'd9, 4'd8, 4'd7, 4'd6, 4'd0, 4'd4, 4'd3, 4'd2, 4'd1},
    '{4'd6, 4'd5, 4'd9, 4'd8, 4'd7, 4'd1, 4'd0, 4'd4, 4'd3, 4'd2},
    '{4'd7, 4'd6, 4'd5, 4'd9, 4'd8, 4'd2, 4'd1, 4'd0, 4'd4, 4'd3},
    '{4'd8, 4'd7, 4'd6, 4'd5, 4'd9, 4'd3, 4'd2, 4'd1, 4'd0, 4'd4},
    '{4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0}
  };

  localparam logic [3:0] INV_TAB [10] = '{
    4'd0, 4'd4, 4'd3, 4'd2, 4'd1, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9
  };

  function automatic logic [3:0] perm_of(input logic [2:0] row, input logic [3:0] dig);
    logic [3:0] r;
    r = '0;
    if (dig <= DIGIT_MAX) begin
      r = PERM_TAB[row][dig];
    end
    return r;
  endfunction

  function automatic logic [3:0] mul_of(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] r;
    r = '0;
    if ((a <= DIGIT_MAX) && (b <= DIGIT_MAX)) begin
      r = MUL_TAB[a][b];
    end
    return r;
  endfunction

  function automatic logic [3:0] inv_of(input logic [3:0] a);
    logic [3:0] r;
    r = '0;
    if (a <= DIGIT_MAX) begin
      r = INV_TAB[a];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/verhoeff_check_digit_top.sv
// verhoeff check digit engine
// input channel digit_valid / digit_ready / digit_word: one decimal digit per
// word, rightmost digit first; last marks the leftmost digit of a number and
// kind picks validate (0) or generate (1) for that digit
// output channel res_valid / res_ready / res_word: one word per number, given
// after its last digit: valid_res, check_digit and the sticky digit_error
// throughput: one digit per cycle while the queue has room, sustained across numbers
// a last digit's front lookup lands in the queue at the accepting edge, and the
// d5 fold then fills the output register from the queue once nothing waits
// ahead of it in the queue
// the front keeps the position count and does the permutation lookup; a
// two-word queue separates it from the back, which folds the check value
// when the receiver stalls, the back keeps folding digits that end no number;
// the queue fills and digit_ready drops only when a finished result waits
// reset clears the position, check value, error flag, queue and res_valid
module verhoeff_check_digit_top import vcd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      digit_valid,
  output logic      digit_ready,
  input  in_word_t  digit_word,
  output logic      res_valid,
  input  logic      res_ready,
  output out_word_t res_word
);

  q_entry_t  fr_entry;
  q_entry_t  bk_entry;
  q_status_t q_stat;
  logic      take;
  logic      pop;

  // accept whenever the queue has room
  assign digit_ready = !q_stat.full;
  assign take        = digit_valid && digit_ready;

  // front: position count and permutation row lookup
  vcd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .word  (digit_word),
    .entry (fr_entry)
  );

  // short queue between front and back
  vcd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .wr_entry (fr_entry),
    .pop      (pop),
    .rd_entry (bk_entry),
    .status   (q_stat)
  );

  // back: d5 fold, result register
  vcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .entry     (bk_entry),
    .avail     (!q_stat.empty),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

  // an errored number reports neither a pass nor a check digit
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.digit_error |->
      !res_word.valid_res && res_word.check_digit == 4'd0)
    else $error("error word carries a result");

  // zero check value is the only one whose inverse is zero
  a_pass_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_word.digit_error |->
      res_word.valid_res == (res_word.check_digit == 4'd0))
    else $error("valid_res disagrees with check_digit");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_word.check_digit <= DIGIT_MAX)
    else $error("check digit out of range");

  // reset leaves the queue empty and res_valid low
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> q_stat.empty && !res_valid)
    else $error("state not cleared by reset");

endmodule

// File: rtl/core/vcd_front.sv
module vcd_front import vcd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  in_word_t  word,
  output q_entry_t  entry
);

  logic [2:0] position;
  logic [2:0] row;

  // generate mode looks one row ahead
  assign row = position + {2'b00, word.kind};

  always_comb begin
    entry.err  = (word.digit > DIGIT_MAX);
    entry.perm = perm_of(row, word.digit);
    entry.last = word.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (take) begin
      position <= word.last ? 3'd0 : position + 3'd1;
    end
  end

endmodule

// File: rtl/core/vcd_fifo.sv
module vcd_fifo import vcd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  wr_entry,
  input  logic      pop,
  output q_entry_t  rd_entry,
  output q_status_t status
);

  q_entry_t        slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign rd_entry     = slots[rd_ptr];
  assign status.full  = (count == Q_CW'(Q_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/vcd_back.sv
module vcd_back import vcd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_entry_t  entry,
  input  logic      avail,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_ready,
  output out_word_t res_word
);

  logic [3:0] check_value;
  logic       error_seen;
  logic [3:0] cv_next;
  logic       err_next;
  logic       out_free;

  assign out_free = !res_valid || res_ready;
  // digits that end no number never wait on the output register
  assign pop      = avail && (!entry.last || out_free);

  always_comb begin
    cv_next  = entry.err ? check_value : mul_of(check_value, entry.perm);
    err_next = error_seen || entry.err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_value <= '0;
      error_seen  <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (pop) begin
        if (entry.last) begin
          check_value <= '0;
          error_seen  <= 1'b0;
          res_valid   <= 1'b1;
        end else begin
          check_value <= cv_next;
          error_seen  <= err_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && entry.last) begin
      if (err_next) begin
        res_word.valid_res   <= 1'b0;
        res_word.check_digit <= '0;
        res_word.digit_error <= 1'b1;
      end else begin
        res_word.valid_res   <= (cv_next == 4'd0);
        res_word.check_digit <= inv_of(cv_next);
        res_word.digit_error <= 1'b0;
      end
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench import vcd_pkg::*;;

  // kind bit values carried with each digit
  localparam logic KIND_VALIDATE = 1'b0;
  localparam logic KIND_GENERATE = 1'b1;

  // cycles with no handshake on either channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // cycles run after the last result is checked, before the run ends
  localparam int TAIL_CYCLES = 8;

  // verhoeff permutation rows, row 0 is the identity
  localparam logic [3:0] ROW_PERM [8][10] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9},
    '{4'd1, 4'd5, 4'd7, 4'd6, 4'd2, 4'd8, 4'd3, 4'd0, 4'd9, 4'd4},
    '{4'd5, 4'd8, 4'd0, 4'd3, 4'd7, 4'd9, 4'd6, 4'd1, 4'd4, 4'd2},
    '{4'd8, 4'd9, 4'd1, 4'd6, 4'd0, 4'd4, 4'd3, 4'd5, 4'd2, 4'd7},
    '{4'd9, 4'd4, 4'd5, 4'd3, 4'd1, 4'd2, 4'd6, 4'd8, 4'd7, 4'd0},
    '{4'd4, 4'd2, 4'd8, 4'd6, 4'd5, 4'd7, 4'd3, 4'd9, 4'd0, 4'd1},
    '{4'd2, 4'd7, 4'd9, 4'd3, 4'd8, 4'd0, 4'd6, 4'd4, 4'd1, 4'd5},
    '{4'd7, 4'd0, 4'd4, 4'd6, 4'd9, 4'd1, 4'd3, 4'd2, 4'd5, 4'd8}
  };

  // d5 group product, rotations 0-4 and reflections 5-9
  localparam logic [3:0] D5_PRODUCT [10][10] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9},
    '{4'd1, 4'd2, 4'd3, 4'd4, 4'd0, 4'd6, 4'd7, 4'd8, 4'd9, 4'd5},
    '{4'd2, 4'd3, 4'd4, 4'd0, 4'd1, 4'd7, 4'd8, 4'd9, 4'd5, 4'd6},
    '{4'd3, 4'd4, 4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd5, 4'd6, 4'd7},
    '{4'd4, 4'd0, 4'd1, 4'd2, 4'd3, 4'd9, 4'd5, 4'd6, 4'd7, 4'd8},
    '{4'd5, 4'd9, 4'd8, 4'd7, 4'd6, 4'd0, 4'd4, 4'd3, 4'd2, 4'd1},
    '{4'd6, 4'd5, 4'd9, 4'd8, 4'd7, 4'd1, 4'd0, 4'd4, 4'd3, 4'd2},
    '{4'd7, 4'd6, 4'd5, 4'd9, 4'd8, 4'd2, 4'd1, 4'd0, 4'd4, 4'd3},
    '{4'd8, 4'd7, 4'd6, 4'd5, 4'd9, 4'd3, 4'd2, 4'd1, 4'd0, 4'd4},
    '{4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0}
  };

  localparam logic [3:0] D5_INVERSE [10] = '{
    4'd0, 4'd4, 4'd3, 4'd2, 4'd1, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9
  };

  // one digit waiting to be sent: idle cycles before it, and whether the
  // sender holds it back until every pending check result has come out
  typedef struct {
    in_word_t word;
    int       gap;
    bit       drain_first;
  } digit_job_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      digit_valid = 1'b0;
  logic      digit_ready;
  in_word_t  digit_word = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  out_word_t res_word;

  digit_job_t digit_jobs[$];
  out_word_t  expected_checks[$];

  // predictor state for the number being folded
  logic [3:0] check_acc = 4'd0;
  logic [2:0] digit_pos = 3'd0;
  logic       bad_digit_seen = 1'b0;

  bit digit_taken = 1'b0;
  int idle_cycles = 0;
  int fail_count = 0;
  int queued_digits = 0;

  // receiver stall state
  int stall_left = 0;
  int stall_level = 0;
  int rx_cycle = 0;

  verhoeff_check_digit_top u_top (
    .clk         (clk),
    .rst         (rst),
    .digit_valid (digit_valid),
    .digit_ready (digit_ready),
    .digit_word  (digit_word),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_word    (res_word)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // idle length for one gap: level 0 never idles, level 2 idles most often;
  // most idles are short, a few are long
  function automatic int pick_gap(input int level);
    int pct;
    pct = (level == 0) ? 0 : ((level == 1) ? 20 : 50);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic queue_digit(input logic [3:0] dig, input logic kind, input logic last,
                             input int gap, input bit drain_first);
    digit_job_t job;
    job.word.digit = dig;
    job.word.kind = kind;
    job.word.last = last;
    job.gap = gap;
    job.drain_first = drain_first;
    digit_jobs.push_back(job);
    queued_digits++;
  endtask

  // one random number; a share of them is a payload plus its own check digit
  // so that validate comes out true, the rest is free content, some of it
  // with bad digits or a kind bit that flips mid-number
  task automatic queue_random_number(input int level, input bit drain_first);
    int len;
    int err_at;
    int r;
    bit mixed;
    bit self_checking;
    logic kind;
    logic [3:0] dig;
    logic [3:0] acc;
    logic [3:0] payload[$];
    r = $urandom_range(0, 99);
    len = (r < 70) ? $urandom_range(1, 8) : ((r < 95) ? $urandom_range(9, 16)
                                                      : $urandom_range(17, 24));
    kind = $urandom_range(0, 1);
    mixed = ($urandom_range(0, 19) == 0);
    err_at = ($urandom_range(0, 24) == 0) ? $urandom_range(0, len - 1) : -1;
    self_checking = ($urandom_range(0, 99) < 30);
    if (self_checking) begin
      // fold the payload as generate would, then send check digit first
      acc = 4'd0;
      for (int i = 0; i < len; i++) begin
        dig = $urandom_range(0, 9);
        payload.push_back(dig);
        acc = D5_PRODUCT[acc][ROW_PERM[(i + 1) % 8][dig]];
      end
      queue_digit(D5_INVERSE[acc], KIND_VALIDATE, 1'b0, pick_gap(level), drain_first);
      for (int i = 0; i < len; i++) begin
        queue_digit(payload[i], KIND_VALIDATE, i == len - 1, pick_gap(level), 1'b0);
      end
    end else begin
      for (int i = 0; i < len; i++) begin
        dig = (i == err_at) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
        queue_digit(dig, mixed ? logic'($urandom_range(0, 1)) : kind, i == len - 1,
                    pick_gap(level), drain_first && (i == 0));
      end
    end
  endtask

  // fold one accepted digit into the predictor; a last digit yields a result
  task automatic fold_verhoeff_digit(input in_word_t w);
    logic [2:0] row;
    out_word_t res;
    if (w.digit > DIGIT_MAX) begin
      bad_digit_seen = 1'b1;
    end else begin
      row = digit_pos + ((w.kind == KIND_GENERATE) ? 3'd1 : 3'd0);
      check_acc = D5_PRODUCT[check_acc][ROW_PERM[row][w.digit]];
    end
    digit_pos = digit_pos + 3'd1;
    if (w.last) begin
      if (bad_digit_seen) begin
        res.valid_res = 1'b0;
        res.check_digit = 4'd0;
        res.digit_error = 1'b1;
      end else begin
        res.valid_res = (check_acc == 4'd0);
        res.check_digit = D5_INVERSE[check_acc];
        res.digit_error = 1'b0;
      end
      expected_checks.push_back(res);
      check_acc = 4'd0;
      digit_pos = 3'd0;
      bad_digit_seen = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  // sender: present the next digit at the falling edge once the previous
  // one has been taken and its idle gap has run out
  always @(negedge clk) begin
    digit_job_t job;
    logic v_n;
    in_word_t w_n;
    v_n = digit_valid;
    w_n = digit_word;
    if (!rst) begin
      if (digit_valid && digit_taken) v_n = 1'b0;
      if (!v_n && (digit_jobs.size() > 0)) begin
        job = digit_jobs[0];
        if (job.gap > 0) begin
          job.gap--;
          digit_jobs[0] = job;
        end else if (!job.drain_first || (expected_checks.size() == 0)) begin
          // a drain point waits here until the result queue is empty
          void'(digit_jobs.pop_front());
          w_n = job.word;
          v_n = 1'b1;
        end
      end
    end
    digit_valid <= v_n;
    digit_word <= w_n;
  end

  // receiver: stalls of random length, with the stall mix redrawn periodically
  // so some stretches never stall
  always @(negedge clk) begin
    int r;
    rx_cycle++;
    if ((rx_cycle % 200) == 0) stall_level = $urandom_range(0, 2);
    if ((stall_left == 0) && (stall_level != 0)) begin
      r = $urandom_range(0, 99);
      if (r < ((stall_level == 1) ? 15 : 40)) begin
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                : $urandom_range(10, 30);
      end
    end
    res_ready <= rst ? 1'b0 : (stall_left == 0);
    if (stall_left > 0) stall_left--;
  end

  // monitor: predict on every accepted digit, check every accepted result
  always @(posedge clk) begin
    out_word_t want;
    bit res_taken;
    digit_taken = 1'b0;
    if (!rst) begin
      digit_taken = digit_valid && digit_ready;
      res_taken = res_valid && res_ready;
      if (digit_taken) fold_verhoeff_digit(digit_word);
      if (res_taken) begin
        if (expected_checks.size() == 0) begin
          $display("[%0t] result word with nothing expected", $realtime);
          fail_count++;
        end else begin
          want = expected_checks.pop_front();
          if (res_word.valid_res !== want.valid_res)
            report_mismatch("valid_res", res_word.valid_res, want.valid_res);
          if (res_word.check_digit !== want.check_digit)
            report_mismatch("check_digit", res_word.check_digit, want.check_digit);
          if (res_word.digit_error !== want.digit_error)
            report_mismatch("digit_error", res_word.digit_error, want.digit_error);
        end
      end
      idle_cycles = (digit_taken || res_taken) ? 0 : idle_cycles + 1;
    end
  end

  // watchdog: no word moving on either channel for too long
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int level;
    // directed numbers, all digits rightmost first
    // generate on 236 must give check digit 3
    queue_digit(4'd6, KIND_GENERATE, 1'b0, 0, 1'b0);
    queue_digit(4'd3, KIND_GENERATE, 1'b0, 0, 1'b0);
    queue_digit(4'd2, KIND_GENERATE, 1'b1, 0, 1'b0);
    // validate on 2363 must pass
    queue_digit(4'd3, KIND_VALIDATE, 1'b0, 0, 1'b0);
    queue_digit(4'd6, KIND_VALIDATE, 1'b0, 1, 1'b0);
    queue_digit(4'd3, KIND_VALIDATE, 1'b0, 0, 1'b0);
    queue_digit(4'd2, KIND_VALIDATE, 1'b1, 0, 1'b0);
    // single-digit numbers at the digit extremes
    queue_digit(4'd0, KIND_VALIDATE, 1'b1, 0, 1'b0);
    queue_digit(4'd9, KIND_GENERATE, 1'b1, 2, 1'b0);
    // a bad digit in the middle leaves the check value alone but sets the error
    queue_digit(4'd5, KIND_VALIDATE, 1'b0, 0, 1'b0);
    queue_digit(4'd15, KIND_VALIDATE, 1'b0, 0, 1'b0);
    queue_digit(4'd2, KIND_VALIDATE, 1'b1, 0, 1'b0);
    // bad digit as the only and last digit
    queue_digit(4'd10, KIND_GENERATE, 1'b1, 0, 1'b0);
    // kind flips from digit to digit within one number
    queue_digit(4'd3, KIND_GENERATE, 1'b0, 0, 1'b0);
    queue_digit(4'd7, KIND_VALIDATE, 1'b0, 0, 1'b0);
    queue_digit(4'd1, KIND_GENERATE, 1'b1, 0, 1'b0);
    // long number so the position wraps past 8
    for (int i = 0; i < 9; i++) begin
      queue_digit(4'd9, KIND_GENERATE, i == 8, 0, 1'b0);
    end

    // random numbers; the first one waits for the directed results to drain
    level = 0;
    queue_random_number(level, 1'b1);
    while (queued_digits < 945) begin
      if ($urandom_range(0, 14) == 0) level = $urandom_range(0, 2);
      queue_random_number(level, $urandom_range(0, 29) == 0);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // everything sent, then everything checked, then a short tail
    while ((digit_jobs.size() != 0) || digit_valid) @(posedge clk);
    while (expected_checks.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
